>>> design/smpe_pkg.sv
// Shared format codes, register indexes and helper functions for the mouse packet encoder
package smpe_pkg;

    // report format codes
    localparam logic [3:0] FMT_BP1_ABS = 4'd0;
    localparam logic [3:0] FMT_BP1_REL = 4'd1;
    localparam logic [3:0] FMT_MM      = 4'd2;
    localparam logic [3:0] FMT_PB3     = 4'd3;
    localparam logic [3:0] FMT_PB5     = 4'd4;
    localparam logic [3:0] FMT_MS      = 4'd5;
    localparam logic [3:0] FMT_HEX     = 4'd6;
    localparam logic [3:0] FMT_MS4     = 4'd7;
    localparam logic [3:0] FMT_WHEEL   = 4'd8;

    // configuration register indexes
    localparam logic REG_FORMAT  = 1'b0;
    localparam logic REG_BUTTONS = 1'b1;

    // reset values of the configuration registers
    localparam logic [3:0] FORMAT_RESET  = FMT_MS;
    localparam logic [2:0] BUTTONS_RESET = 3'd2;

    localparam int PKT_MAX = 5;

    typedef logic [7:0] pkt_byte_t;

    // clamp a 13-bit signed value into [lo, hi] and return its low byte
    function automatic pkt_byte_t sat_byte(input logic signed [12:0] v,
                                           input logic signed [12:0] lo,
                                           input logic signed [12:0] hi);
        logic signed [12:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r[7:0];
    endfunction

    // uppercase ascii hex digit of a nibble
    function automatic pkt_byte_t hex_digit(input logic [3:0] d);
        pkt_byte_t r;
        if (d < 4'd10)
            r = 8'h30 + {4'h0, d};
        else
            r = 8'h41 + {4'h0, d} - 8'd10;
        return r;
    endfunction

endpackage

>>> design/serial_mouse_packet_encoder.sv
// Serial mouse packet encoder: formats one report into a 3 to 5 byte packet, or none for an unknown format
// The first byte of a packet is offered in the cycle after its request is accepted.
// A packet is sent one byte per cycle on the byte channel while out_ready is high; the
// next request is taken in the cycle the last byte is delivered, and a request in an
// unknown format sends nothing and leaves the encoder ready for the next request.
// Reset: no packet pending, report_format = 5, button_count = 2.
module serial_mouse_packet_encoder (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [11:0] move_x,
    input  logic signed [11:0] move_y,
    input  logic signed [3:0]  move_z,
    input  logic [2:0]         button_bits,
    input  logic               middle_toggled,
    // byte channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         packet_byte,
    output logic               final_byte
);

    logic [3:0] format_reg;
    logic [2:0] buttons_reg;

    smpe_pkg::pkt_byte_t pkt_reg [smpe_pkg::PKT_MAX];
    smpe_pkg::pkt_byte_t pkt_next [smpe_pkg::PKT_MAX];
    logic [2:0]          last_reg;
    logic [2:0]          last_next;
    logic [2:0]          idx_reg;
    logic                valid_reg;
    logic                has_bytes;

    logic signed [12:0] x13;
    logic signed [12:0] y13;
    logic signed [12:0] yneg13;
    logic signed [4:0]  zneg5;
    logic [11:0]        bp_y;
    logic [3:0]         ms_z;
    logic [7:0]         x128;
    logic [7:0]         y128;
    logic [7:0]         yn128;
    logic [7:0]         x127;
    logic [7:0]         yn127;
    logic [7:0]         x127_abs;
    logic [7:0]         yn127_abs;
    logic               left;
    logic               right;
    logic               mid;
    logic               mid_en;
    logic               take;
    logic               done;
    logic               accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg  <= smpe_pkg::FORMAT_RESET;
            buttons_reg <= smpe_pkg::BUTTONS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                smpe_pkg::REG_FORMAT:  format_reg  <= cfg_data;
                smpe_pkg::REG_BUTTONS: buttons_reg <= cfg_data[2:0];
                default:               format_reg  <= format_reg;
            endcase
        end
    end

    // saturated and negated deltas
    assign left   = button_bits[0];
    assign right  = button_bits[1];
    assign mid    = button_bits[2];
    assign mid_en = buttons_reg >= 3'd3;

    assign x13    = {move_x[11], move_x};
    assign y13    = {move_y[11], move_y};
    assign yneg13 = -y13;
    assign zneg5  = -{move_z[3], move_z};

    assign bp_y  = (yneg13 > 13'sd2047) ? 12'h7ff : yneg13[11:0];
    assign ms_z  = (zneg5 > 5'sd7) ? 4'h7 : zneg5[3:0];
    assign x128  = smpe_pkg::sat_byte(x13, -13'sd128, 13'sd127);
    assign y128  = smpe_pkg::sat_byte(y13, -13'sd128, 13'sd127);
    assign yn128 = smpe_pkg::sat_byte(yneg13, -13'sd128, 13'sd127);
    assign x127  = smpe_pkg::sat_byte(x13, -13'sd127, 13'sd127);
    assign yn127 = smpe_pkg::sat_byte(yneg13, -13'sd127, 13'sd127);

    assign x127_abs  = x127[7] ? (8'd0 - x127) : x127;
    assign yn127_abs = yn127[7] ? (8'd0 - yn127) : yn127;

    // packet assembly for the selected format
    always_comb
    begin
        for (int k = 0; k < smpe_pkg::PKT_MAX; k++)
            pkt_next[k] = 8'h00;
        last_next = 3'd0;
        has_bytes = 1'b1;
        unique case (format_reg)
            smpe_pkg::FMT_BP1_ABS, smpe_pkg::FMT_BP1_REL:
            begin
                pkt_next[0] = {3'b100, left, mid_en & mid, right, 2'b00};
                pkt_next[1] = {2'b00, move_x[5:0]};
                pkt_next[2] = {2'b00, move_x[11:6]};
                pkt_next[3] = {2'b00, bp_y[5:0]};
                pkt_next[4] = {2'b00, bp_y[11:6]};
                last_next   = 3'd4;
            end
            smpe_pkg::FMT_MM:
            begin
                pkt_next[0] = {3'b100, ~x127[7], ~yn127[7], left, mid_en & mid, right};
                pkt_next[1] = {1'b0, x127_abs[6:0]};
                pkt_next[2] = {1'b0, yn127_abs[6:0]};
                last_next   = 3'd2;
            end
            smpe_pkg::FMT_PB3:
            begin
                pkt_next[0] = {5'b10000, left, mid_en & mid, right};
                pkt_next[1] = x128;
                pkt_next[2] = yn128;
                last_next   = 3'd2;
            end
            smpe_pkg::FMT_PB5:
            begin
                pkt_next[0] = {5'b10000, ~left, ~(mid_en & mid), ~right};
                pkt_next[1] = x128;
                pkt_next[2] = yn128;
                pkt_next[3] = x128;
                pkt_next[4] = yn128;
                last_next   = 3'd4;
            end
            smpe_pkg::FMT_MS, smpe_pkg::FMT_MS4, smpe_pkg::FMT_WHEEL:
            begin
                pkt_next[0] = {2'b01, left, right, y128[7:6], x128[7:6]};
                pkt_next[1] = {2'b00, x128[5:0]};
                pkt_next[2] = {2'b00, y128[5:0]};
                last_next   = 3'd2;
                // optional fourth byte: middle button or wheel
                if (buttons_reg == 3'd3)
                begin
                    if (format_reg == smpe_pkg::FMT_MS)
                    begin
                        if (mid)
                        begin
                            pkt_next[3] = 8'h20;
                            last_next   = 3'd3;
                        end
                    end
                    else if (middle_toggled)
                    begin
                        pkt_next[3] = 8'h00;
                        last_next   = 3'd3;
                    end
                end
                else if (buttons_reg == 3'd4)
                begin
                    pkt_next[3] = {3'b000, mid, ms_z};
                    last_next   = 3'd3;
                end
            end
            smpe_pkg::FMT_HEX:
            begin
                pkt_next[0] = smpe_pkg::hex_digit({1'b0, left, mid_en & mid, right});
                pkt_next[1] = smpe_pkg::hex_digit(x128[7:4]);
                pkt_next[2] = smpe_pkg::hex_digit(x128[3:0]);
                pkt_next[3] = smpe_pkg::hex_digit(yn128[7:4]);
                pkt_next[4] = smpe_pkg::hex_digit(yn128[3:0]);
                last_next   = 3'd4;
            end
            default:
            begin
                // unknown format sends nothing
                has_bytes = 1'b0;
            end
        endcase
    end

    // handshake
    assign take     = valid_reg && out_ready;
    assign done     = take && (idx_reg == last_reg);
    assign in_ready = !valid_reg || done;
    assign accept   = in_valid && in_ready;

    // packet control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else if (accept)
        begin
            valid_reg <= has_bytes;
            idx_reg   <= 3'd0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // packet payload
    always_ff @(posedge clk)
    begin
        if (accept && has_bytes)
        begin
            pkt_reg  <= pkt_next;
            last_reg <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign packet_byte = pkt_reg[idx_reg];
    assign final_byte  = idx_reg == last_reg;

    // checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg <= last_reg)
        else $error("byte index beyond packet end");

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (last_reg == 3'd2 || last_reg == 3'd3 || last_reg == 3'd4))
        else $error("packet length outside 3 to 5 bytes");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !done) |=> (valid_reg && idx_reg == $past(idx_reg) + 3'd1))
        else $error("byte index did not advance after delivery");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> in_ready)
        else $error("request refused while no packet pending");

endmodule
